// ----- sv/cbtu_pkg.sv -----
package cbtu_pkg;

    // Field widths fixed by the interface.
    localparam int IN_W   = 32;
    localparam int OUT_W  = 18;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int QUO_W  = 17;
    localparam int REM_W  = 49;
    localparam int PROD_W = 36;
    localparam int DIFF_W = 37;
    localparam int MAG_W  = 21;

    localparam logic [MAG_W-1:0] ONE_Q16 = MAG_W'(65536);

    // Saturate a magnitude to one and give it a sign.
    function automatic logic signed [OUT_W-1:0] cbtu_apply_sign(
        input logic [MAG_W-1:0] mag,
        input logic             neg
    );
        logic [OUT_W-1:0] sat;
        sat = (mag > ONE_Q16) ? OUT_W'(ONE_Q16) : OUT_W'(mag);
        return neg ? -$signed(sat) : $signed(sat);
    endfunction

    // Bring a Q4.32 difference to Q1.16, rounding the magnitude half away from zero.
    function automatic logic signed [OUT_W-1:0] cbtu_round_q16(
        input logic signed [DIFF_W-1:0] d
    );
        logic [DIFF_W-1:0] mag;
        logic [DIFF_W-1:0] sum;
        mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        sum = mag + DIFF_W'(32768);
        return cbtu_apply_sign(sum[16 +: MAG_W], d[DIFF_W-1]);
    endfunction

endpackage

// ----- sv/cbtu_norm.sv -----
module cbtu_norm
    import cbtu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [IN_W-1:0]  comp_x,
    input  logic signed [IN_W-1:0]  comp_y,
    input  logic signed [IN_W-1:0]  comp_z,
    output logic                    out_valid,
    output logic signed [OUT_W-1:0] unit_x,
    output logic signed [OUT_W-1:0] unit_y,
    output logic signed [OUT_W-1:0] unit_z,
    output logic                    zero_len
);

    localparam int SQ_STAGES  = ROOT_W;
    localparam int DIV_STAGES = QUO_W;

    logic signed [IN_W-1:0] comp [0:2];
    logic [IN_W-1:0]        mag_next [0:2];

    // Stage A: magnitudes and squares.
    logic                   a_vld_reg;
    logic [IN_W-1:0]        a_mag_reg [0:2];
    logic                   a_neg_reg [0:2];
    logic [SQ_W-1:0]        a_sq_reg  [0:2];

    // Square root pipeline; entry 0 holds the squared length.
    logic                   s_vld_reg  [0:SQ_STAGES];
    logic [SQ_W-1:0]        s_rem_reg  [0:SQ_STAGES];
    logic [ROOT_W-1:0]      s_root_reg [0:SQ_STAGES];
    logic [IN_W-1:0]        s_mag_reg  [0:SQ_STAGES][0:2];
    logic                   s_neg_reg  [0:SQ_STAGES][0:2];

    // Divider pipeline; entry 0 holds the rounded dividends.
    logic                   d_vld_reg [0:DIV_STAGES];
    logic [ROOT_W-1:0]      d_len_reg [0:DIV_STAGES];
    logic [REM_W-1:0]       d_rem_reg [0:DIV_STAGES][0:2];
    logic [QUO_W-1:0]       d_quo_reg [0:DIV_STAGES][0:2];
    logic                   d_neg_reg [0:DIV_STAGES][0:2];

    logic                   o_vld_reg;
    logic signed [OUT_W-1:0] o_unit_reg [0:2];
    logic                   o_zero_reg;

    assign comp[0] = comp_x;
    assign comp[1] = comp_y;
    assign comp[2] = comp_z;

    // Magnitude of each component; the most negative value maps to 2^31.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = comp[i][IN_W-1] ? IN_W'(-comp[i]) : IN_W'(comp[i]);
        end
    end

    // Stage A registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag_reg[i] <= mag_next[i];
            a_neg_reg[i] <= comp[i][IN_W-1];
            a_sq_reg[i]  <= SQ_W'(mag_next[i]) * SQ_W'(mag_next[i]);
        end
    end

    // Stage B: squared length; the sum of three squares stays below 2^64.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg[0] <= 1'b0;
        end
        else
        begin
            s_vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_rem_reg[0]  <= a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
        s_root_reg[0] <= '0;
        for (int i = 0; i < 3; i++)
        begin
            s_mag_reg[0][i] <= a_mag_reg[i];
            s_neg_reg[0][i] <= a_neg_reg[i];
        end
    end

    // Floor square root, one root bit per stage from the top down.
    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_sqrt
        localparam int K = SQ_STAGES - 1 - s;
        logic [SQ_W+1:0] trial;
        logic            take;

        assign trial = ((SQ_W+2)'(s_root_reg[s]) << (K + 1)) + ((SQ_W+2)'(1) << (2 * K));
        assign take  = {2'b00, s_rem_reg[s]} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_vld_reg[s+1] <= 1'b0;
            end
            else
            begin
                s_vld_reg[s+1] <= s_vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (take)
            begin
                s_rem_reg[s+1]  <= s_rem_reg[s] - trial[SQ_W-1:0];
                s_root_reg[s+1] <= s_root_reg[s] | (ROOT_W'(1) << K);
            end
            else
            begin
                s_rem_reg[s+1]  <= s_rem_reg[s];
                s_root_reg[s+1] <= s_root_reg[s];
            end
            for (int i = 0; i < 3; i++)
            begin
                s_mag_reg[s+1][i] <= s_mag_reg[s][i];
                s_neg_reg[s+1][i] <= s_neg_reg[s][i];
            end
        end
    end

    // Dividend set-up: component times 2^16 plus half the length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg[0] <= 1'b0;
        end
        else
        begin
            d_vld_reg[0] <= s_vld_reg[SQ_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        d_len_reg[0] <= s_root_reg[SQ_STAGES];
        for (int i = 0; i < 3; i++)
        begin
            d_rem_reg[0][i] <= {1'b0, s_mag_reg[SQ_STAGES][i], 16'b0}
                               + REM_W'(s_root_reg[SQ_STAGES] >> 1);
            d_quo_reg[0][i] <= '0;
            d_neg_reg[0][i] <= s_neg_reg[SQ_STAGES][i];
        end
    end

    // Restoring division, one quotient bit per stage; the quotient never exceeds 2^16.
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        localparam int K = DIV_STAGES - 1 - j;
        logic [REM_W-1:0] shifted_len;

        assign shifted_len = REM_W'(d_len_reg[j]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                d_vld_reg[j+1] <= d_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            d_len_reg[j+1] <= d_len_reg[j];
            for (int i = 0; i < 3; i++)
            begin
                if (d_rem_reg[j][i] >= shifted_len)
                begin
                    d_rem_reg[j+1][i] <= d_rem_reg[j][i] - shifted_len;
                    d_quo_reg[j+1][i] <= d_quo_reg[j][i] | (QUO_W'(1) << K);
                end
                else
                begin
                    d_rem_reg[j+1][i] <= d_rem_reg[j][i];
                    d_quo_reg[j+1][i] <= d_quo_reg[j][i];
                end
                d_neg_reg[j+1][i] <= d_neg_reg[j][i];
            end
        end
    end

    // Output stage: sign, saturation and the zero-length flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else
        begin
            o_vld_reg <= d_vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        o_zero_reg <= (d_len_reg[DIV_STAGES] == '0);
        for (int i = 0; i < 3; i++)
        begin
            o_unit_reg[i] <= cbtu_apply_sign(MAG_W'(d_quo_reg[DIV_STAGES][i]),
                                             d_neg_reg[DIV_STAGES][i]);
        end
    end

    assign out_valid = o_vld_reg;
    assign unit_x    = o_unit_reg[0];
    assign unit_y    = o_unit_reg[1];
    assign unit_z    = o_unit_reg[2];
    assign zero_len  = o_zero_reg;

endmodule

// ----- sv/cbtu_cross.sv -----
module cbtu_cross
    import cbtu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [OUT_W-1:0] a_x,
    input  logic signed [OUT_W-1:0] a_y,
    input  logic signed [OUT_W-1:0] a_z,
    input  logic signed [OUT_W-1:0] b_x,
    input  logic signed [OUT_W-1:0] b_y,
    input  logic signed [OUT_W-1:0] b_z,
    output logic                    out_valid,
    output logic signed [OUT_W-1:0] r_x,
    output logic signed [OUT_W-1:0] r_y,
    output logic signed [OUT_W-1:0] r_z
);

    logic                     p_vld_reg;
    logic signed [PROD_W-1:0] p_reg [0:5];
    logic                     r_vld_reg;
    logic signed [OUT_W-1:0]  r_reg [0:2];

    // Product stage: the six partial products of a x b.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= in_valid;
            r_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg[0] <= a_y * b_z;
        p_reg[1] <= a_z * b_y;
        p_reg[2] <= a_z * b_x;
        p_reg[3] <= a_x * b_z;
        p_reg[4] <= a_x * b_y;
        p_reg[5] <= a_y * b_x;
    end

    // Difference stage: subtract, round to Q1.16 and saturate.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_reg[i] <= cbtu_round_q16(DIFF_W'(p_reg[2*i]) - DIFF_W'(p_reg[2*i+1]));
        end
    end

    assign out_valid = r_vld_reg;
    assign r_x       = r_reg[0];
    assign r_y       = r_reg[1];
    assign r_z       = r_reg[2];

endmodule

// ----- sv/camera_basis_from_target_up_top.sv -----
// Channel   Handshake                 Payload
// input     start (busy always low)   target_x/y/z, up_x/y/z, Q16.16
// result    done strobe, one cycle    right_*, upward_*, forward_*, zero_length_error
//
// A transaction may start in every cycle; its result appears on done once it has passed
// through both normalizers and both cross products. Each normalizer is a pipeline of
// squares, their sum, the 32-stage square root, the dividend set-up, the 17-stage divider
// and the output stage. Each of the two cross products adds two stages.
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline always advances and busy stays low.
module camera_basis_from_target_up_top
    import cbtu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  target_x,
    input  logic signed [IN_W-1:0]  target_y,
    input  logic signed [IN_W-1:0]  target_z,
    input  logic signed [IN_W-1:0]  up_x,
    input  logic signed [IN_W-1:0]  up_y,
    input  logic signed [IN_W-1:0]  up_z,
    output logic                    done,
    output logic signed [OUT_W-1:0] right_x,
    output logic signed [OUT_W-1:0] right_y,
    output logic signed [OUT_W-1:0] right_z,
    output logic signed [OUT_W-1:0] upward_x,
    output logic signed [OUT_W-1:0] upward_y,
    output logic signed [OUT_W-1:0] upward_z,
    output logic signed [OUT_W-1:0] forward_x,
    output logic signed [OUT_W-1:0] forward_y,
    output logic signed [OUT_W-1:0] forward_z,
    output logic                    zero_length_error
);

    localparam int LATENCY = 57;

    logic                    n_vld;
    logic                    un_vld;
    logic                    n_zero;
    logic                    un_zero;
    logic signed [OUT_W-1:0] n [0:2];
    logic signed [OUT_W-1:0] un [0:2];
    logic                    u_vld;
    logic signed [OUT_W-1:0] u [0:2];
    logic                    v_vld;
    logic signed [OUT_W-1:0] v [0:2];

    logic signed [OUT_W-1:0] n_d_reg [0:3][0:2];
    logic signed [OUT_W-1:0] u_d_reg [0:1][0:2];
    logic                    err_d_reg [0:3];

    assign busy = 1'b0;

    // Normalizers for the target and the up vector run side by side.
    cbtu_norm u_norm_target (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .comp_x   (target_x),
        .comp_y   (target_y),
        .comp_z   (target_z),
        .out_valid(n_vld),
        .unit_x   (n[0]),
        .unit_y   (n[1]),
        .unit_z   (n[2]),
        .zero_len (n_zero)
    );

    cbtu_norm u_norm_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .comp_x   (up_x),
        .comp_y   (up_y),
        .comp_z   (up_z),
        .out_valid(un_vld),
        .unit_x   (un[0]),
        .unit_y   (un[1]),
        .unit_z   (un[2]),
        .zero_len (un_zero)
    );

    // Right vector U = normalized up x N.
    cbtu_cross u_cross_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (n_vld),
        .a_x      (un[0]),
        .a_y      (un[1]),
        .a_z      (un[2]),
        .b_x      (n[0]),
        .b_y      (n[1]),
        .b_z      (n[2]),
        .out_valid(u_vld),
        .r_x      (u[0]),
        .r_y      (u[1]),
        .r_z      (u[2])
    );

    // Upward vector V = N x U, with N delayed to meet U.
    cbtu_cross u_cross_upward (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (u_vld),
        .a_x      (n_d_reg[1][0]),
        .a_y      (n_d_reg[1][1]),
        .a_z      (n_d_reg[1][2]),
        .b_x      (u[0]),
        .b_y      (u[1]),
        .b_z      (u[2]),
        .out_valid(v_vld),
        .r_x      (v[0]),
        .r_y      (v[1]),
        .r_z      (v[2])
    );

    // Delay lines that keep N, U and the error flag aligned with V.
    always_ff @(posedge clk)
    begin
        err_d_reg[0] <= n_zero | un_zero;
        for (int s = 1; s < 4; s++)
        begin
            err_d_reg[s] <= err_d_reg[s-1];
        end
        for (int i = 0; i < 3; i++)
        begin
            n_d_reg[0][i] <= n[i];
            for (int s = 1; s < 4; s++)
            begin
                n_d_reg[s][i] <= n_d_reg[s-1][i];
            end
            u_d_reg[0][i] <= u[i];
            u_d_reg[1][i] <= u_d_reg[0][i];
        end
    end

    // A zero-length input forces all nine basis fields to zero.
    assign done              = v_vld;
    assign zero_length_error = err_d_reg[3];
    assign right_x   = err_d_reg[3] ? '0 : u_d_reg[1][0];
    assign right_y   = err_d_reg[3] ? '0 : u_d_reg[1][1];
    assign right_z   = err_d_reg[3] ? '0 : u_d_reg[1][2];
    assign upward_x  = err_d_reg[3] ? '0 : v[0];
    assign upward_y  = err_d_reg[3] ? '0 : v[1];
    assign upward_z  = err_d_reg[3] ? '0 : v[2];
    assign forward_x = err_d_reg[3] ? '0 : n_d_reg[3][0];
    assign forward_y = err_d_reg[3] ? '0 : n_d_reg[3][1];
    assign forward_z = err_d_reg[3] ? '0 : n_d_reg[3][2];

`ifndef SYNTHESIS
    // A zero target must come out flagged after the full pipeline latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && target_x == 0 && target_y == 0 && target_z == 0)
        |-> ##LATENCY (done && zero_length_error))
        else $error("zero target not flagged at expected latency");

    // Every accepted transaction yields exactly one result after the latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result strobe missing after a transaction");

    // The x and y components of the normalized target stay within plus or minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (forward_x <= 18'sd65536 && forward_x >= -18'sd65536
               && forward_y <= 18'sd65536 && forward_y >= -18'sd65536))
        else $error("forward component out of range");

    // The two normalizers must stay in step.
    assert property (@(posedge clk) disable iff (!rst_n)
        n_vld == un_vld)
        else $error("normalizer valid bits out of step");
`endif

endmodule

// ----- dv/tb_camera_basis_from_target_up_top.sv -----
module tb_camera_basis_from_target_up_top;
    import cbtu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 57;
    localparam int WATCH_MAX  = 4 * (LATENCY + 12) + 100;
    localparam int N_RANDOM   = 1750;
    localparam logic signed [IN_W-1:0] Q_ONE = 32'sd65536;
    localparam logic signed [IN_W-1:0] I_MIN = 32'sh8000_0000;
    localparam logic signed [IN_W-1:0] I_MAX = 32'sh7FFF_FFFF;

    typedef logic signed [IN_W-1:0]  vin_t [3];
    typedef logic signed [OUT_W-1:0] vout_t [3];

    typedef struct {
        logic signed [OUT_W-1:0] r [3];
        logic signed [OUT_W-1:0] v [3];
        logic signed [OUT_W-1:0] f [3];
        logic                    err;
    } basis_t;

    typedef struct {
        logic signed [IN_W-1:0] t [3];
        logic signed [IN_W-1:0] u [3];
        bit                     typed;
        basis_t                 want;
    } vec_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [IN_W-1:0] target_x = '0, target_y = '0, target_z = '0;
    logic signed [IN_W-1:0] up_x = '0, up_y = '0, up_z = '0;
    logic done;
    logic signed [OUT_W-1:0] right_x, right_y, right_z;
    logic signed [OUT_W-1:0] upward_x, upward_y, upward_z;
    logic signed [OUT_W-1:0] forward_x, forward_y, forward_z;
    logic zero_length_error;

    basis_t pending_basis [$];
    int     n_errors = 0;
    int     idle_cycles = 0;

    always #4 clk = ~clk;

    camera_basis_from_target_up_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z),
        .done(done),
        .right_x(right_x), .right_y(right_y), .right_z(right_z),
        .upward_x(upward_x), .upward_y(upward_y), .upward_z(upward_z),
        .forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
        .zero_length_error(zero_length_error)
    );

    // Saturate a magnitude to one and apply the sign.
    function automatic logic signed [OUT_W-1:0] signed_sat(longint unsigned mag, bit neg);
        if (mag > 65536)
        begin
            mag = 65536;
        end
        return neg ? -OUT_W'(mag) : OUT_W'(mag);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned rem, root, bitv;
        rem = x;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Normalize a Q16.16 vector to Q1.16; zero when the length floors to zero.
    function automatic bit unit_vector(vin_t c, output vout_t n);
        longint unsigned m [3];
        longint unsigned sq, len;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = c[i] < 0 ? longint'(-longint'(c[i])) : longint'(c[i]);
            sq += m[i] * m[i];
        end
        len = floor_root(sq);
        for (int i = 0; i < 3; i++)
        begin
            n[i] = (len == 0) ? '0 : signed_sat(((m[i] << 16) + (len >> 1)) / len, c[i] < 0);
        end
        return len != 0;
    endfunction

    function automatic logic signed [OUT_W-1:0] round_prod(longint d);
        longint unsigned mag;
        mag = d < 0 ? longint'(-d) : longint'(d);
        return signed_sat((mag + 32768) >> 16, d < 0);
    endfunction

    function automatic vout_t cross_q16(vout_t a, vout_t b);
        vout_t r;
        r[0] = round_prod(longint'(a[1]) * b[2] - longint'(a[2]) * b[1]);
        r[1] = round_prod(longint'(a[2]) * b[0] - longint'(a[0]) * b[2]);
        r[2] = round_prod(longint'(a[0]) * b[1] - longint'(a[1]) * b[0]);
        return r;
    endfunction

    // Camera basis for one target and up pair.
    function automatic basis_t look_at_basis(vin_t t, vin_t u);
        basis_t b;
        vout_t  un;
        bit     ok;
        ok = unit_vector(t, b.f);
        ok = unit_vector(u, un) && ok;
        if (!ok)
        begin
            b.r = '{default: '0};
            b.v = '{default: '0};
            b.f = '{default: '0};
            b.err = 1'b1;
        end
        else
        begin
            b.r = cross_q16(un, b.f);
            b.v = cross_q16(b.f, b.r);
            b.err = 1'b0;
        end
        return b;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Drive one transaction and hold it until accepted.
    task automatic send_vectors(vin_t t, vin_t u, bit typed, basis_t want);
        target_x <= t[0];
        target_y <= t[1];
        target_z <= t[2];
        up_x <= u[0];
        up_y <= u[1];
        up_z <= u[2];
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_basis.push_back(typed ? want : look_at_basis(t, u));
    endtask

    task automatic sender_gap(int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        basis_t w;
        if (rst_n && done)
        begin
            if (pending_basis.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                w = pending_basis.pop_front();
                if (right_x != w.r[0]) report_mismatch("right_x", right_x, w.r[0]);
                if (right_y != w.r[1]) report_mismatch("right_y", right_y, w.r[1]);
                if (right_z != w.r[2]) report_mismatch("right_z", right_z, w.r[2]);
                if (upward_x != w.v[0]) report_mismatch("upward_x", upward_x, w.v[0]);
                if (upward_y != w.v[1]) report_mismatch("upward_y", upward_y, w.v[1]);
                if (upward_z != w.v[2]) report_mismatch("upward_z", upward_z, w.v[2]);
                if (forward_x != w.f[0]) report_mismatch("forward_x", forward_x, w.f[0]);
                if (forward_y != w.f[1]) report_mismatch("forward_y", forward_y, w.f[1]);
                if (forward_z != w.f[2]) report_mismatch("forward_z", forward_z, w.f[2]);
                if (zero_length_error != w.err)
                begin
                    report_mismatch("zero_length_error", zero_length_error, w.err);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction or result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCH_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [IN_W-1:0] rand_comp(int kind);
        case (kind)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            2: return $signed($urandom_range(0, 8)) - 4;
            default: return '0;
        endcase
    endfunction

    // Directed table followed by random vector pairs.
    initial
    begin
        vec_row_t rows [$];
        vec_row_t row;
        basis_t   blank;
        vin_t     t, u;
        int       kind, shape, scale, gap;
        bit       burst;

        blank.r = '{default: '0};
        blank.v = '{default: '0};
        blank.f = '{default: '0};
        blank.err = 1'b0;
        row.typed = 1'b1;

        // Zero target, zero up, then both zero: error with all fields zero.
        row.want = blank;
        row.want.err = 1'b1;
        row.t = '{0, 0, 0};     row.u = '{0, Q_ONE, 0};  rows.push_back(row);
        row.t = '{Q_ONE, 0, 0}; row.u = '{0, 0, 0};      rows.push_back(row);
        row.t = '{0, 0, 0};     row.u = '{0, 0, 0};      rows.push_back(row);
        // Unit x target with unit y up.
        row.want = blank;
        row.want.r = '{0, 0, -65536};
        row.want.v = '{0, 65536, 0};
        row.want.f = '{65536, 0, 0};
        row.t = '{Q_ONE, 0, 0}; row.u = '{0, Q_ONE, 0};  rows.push_back(row);
        // Parallel vectors give zero right and upward vectors.
        row.want = blank;
        row.want.f = '{65536, 0, 0};
        row.t = '{Q_ONE, 0, 0}; row.u = '{Q_ONE, 0, 0};  rows.push_back(row);
        row.t = '{I_MAX, 0, 0}; row.u = '{1, 0, 0};      rows.push_back(row);

        // Remaining rows go through the predictor.
        row.typed = 1'b0;
        row.t = '{I_MIN, I_MIN, I_MIN}; row.u = '{I_MAX, I_MAX, I_MAX}; rows.push_back(row);
        row.t = '{I_MAX, I_MIN, I_MAX}; row.u = '{I_MIN, I_MAX, 0};     rows.push_back(row);
        row.t = '{I_MIN, 0, 0};         row.u = '{0, I_MIN, 0};         rows.push_back(row);
        row.t = '{1, 0, 0};             row.u = '{0, 1, 0};             rows.push_back(row);
        row.t = '{1, 1, 1};             row.u = '{-1, 2, 0};            rows.push_back(row);
        row.t = '{-1, -1, -1};          row.u = '{I_MAX, -1, 1};        rows.push_back(row);
        row.t = '{0, 0, -Q_ONE};        row.u = '{0, Q_ONE, 0};         rows.push_back(row);
        row.t = '{3, 4, 0};             row.u = '{-4, 3, 12};           rows.push_back(row);
        row.t = '{Q_ONE, Q_ONE, 0};     row.u = '{-Q_ONE, -Q_ONE, 0};   rows.push_back(row);
        row.t = '{32'sh0012_3456, -32'sh0000_789A, 32'sh0001_0000};
        row.u = '{-32'sh0003_0000, 32'sh7000_0000, -32'sh0000_0001};    rows.push_back(row);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_vectors(rows[i].t, rows[i].u, rows[i].typed, rows[i].want);
            sender_gap($urandom_range(0, 2) == 0 ? $urandom_range(0, 11) : 0);
        end

        burst = 1'b0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 64 == 0)
            begin
                burst = $urandom_range(0, 2) == 0;
            end
            // Hold off once until the pipeline has drained.
            if (n == N_RANDOM / 2)
            begin
                start <= 1'b0;
                while (pending_basis.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            kind = $urandom_range(0, 3);
            shape = $urandom_range(0, 9);
            for (int k = 0; k < 3; k++)
            begin
                t[k] = rand_comp($urandom_range(0, 5) == 0 ? 3 : kind);
                u[k] = rand_comp($urandom_range(0, 5) == 0 ? 3 : $urandom_range(0, 2));
            end
            if (shape == 0)
            begin
                // Up is a scaled copy of the target.
                scale = $signed($urandom_range(0, 6)) - 3;
                for (int k = 0; k < 3; k++)
                begin
                    t[k] = rand_comp(1);
                    u[k] = t[k] * (scale == 0 ? 1 : scale);
                end
            end
            else if (shape == 1)
            begin
                if ($urandom_range(0, 1)) t = '{0, 0, 0};
                else u = '{0, 0, 0};
            end
            send_vectors(t, u, 1'b0, blank);
            gap = burst ? 0 : $urandom_range(0, 11);
            sender_gap(gap);
        end
        start <= 1'b0;

        while (pending_basis.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 20) @(posedge clk);

        if (n_errors == 0 && pending_basis.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- camera_basis_from_target_up_top.f -----
sv/cbtu_pkg.sv
sv/cbtu_norm.sv
sv/cbtu_cross.sv
sv/camera_basis_from_target_up_top.sv
dv/tb_camera_basis_from_target_up_top.sv
